@@ hdl/lmrk_pkg.sv @@
package lmrk_pkg;

   // configuration register indexes
   localparam int CsrIdxW = 2;
   localparam int CoefW   = 31;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_STEP  = 2'd0,
      CSR_SIGMA = 2'd1,
      CSR_RHO   = 2'd2,
      CSR_BETA  = 2'd3
   } csr_idx_type;

   // request kinds carried on req_tuser
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } req_cmd_type;

   // multiplier operand selects
   typedef enum logic [1:0] {
      OPA_SX    = 2'd0,
      OPA_BETA  = 2'd1,
      OPA_SIGMA = 2'd2,
      OPA_H     = 2'd3
   } opa_sel_type;

   typedef enum logic [2:0] {
      OPB_SY = 3'd0,
      OPB_SZ = 3'd1,
      OPB_D1 = 3'd2,
      OPB_D2 = 3'd3,
      OPB_FX = 3'd4,
      OPB_FY = 3'd5,
      OPB_FZ = 3'd6
   } opb_sel_type;

   // writeback destinations
   typedef enum logic [3:0] {
      DST_T  = 4'd0,
      DST_FX = 4'd1,
      DST_FY = 4'd2,
      DST_FZ = 4'd3,
      DST_MX = 4'd4,
      DST_MY = 4'd5,
      DST_MZ = 4'd6,
      DST_PX = 4'd7,
      DST_PY = 4'd8,
      DST_PZ = 4'd9
   } wb_dst_type;

   // what the rounded product is combined with
   typedef enum logic [2:0] {
      ADD_NONE  = 3'd0,
      ADD_SUB_Y = 3'd1,
      ADD_T_SUB = 3'd2,
      ADD_PX    = 3'd3,
      ADD_PY    = 3'd4,
      ADD_PZ    = 3'd5
   } wb_add_type;

   typedef struct packed {
      logic        load;
      logic        start;
      logic        out_load;
      logic        diff_yx;
      logic        diff_rz;
      logic        src_m;
      logic        mul_en;
      opa_sel_type opa;
      opb_sel_type opb;
      logic        wb_en;
      wb_dst_type  wb_dst;
      wb_add_type  wb_add;
      logic        wb_half;
      logic        count;
   } dp_cmd_type;

   localparam int         UopW    = 4;
   localparam logic [3:0] UopLast = 4'd14;

   // one step of the integration program: a product issued per cycle,
   // the previous product rounded and written back in the same cycle
   function automatic dp_cmd_type rk_uop(input logic [UopW-1:0] idx);
      dp_cmd_type c;
      c = '0;
      unique case (idx)
         4'd0: begin
            c.diff_yx = 1'b1; c.diff_rz = 1'b1;
            c.mul_en = 1'b1; c.opa = OPA_SX; c.opb = OPB_SY;
         end
         4'd1: begin
            c.mul_en = 1'b1; c.opa = OPA_BETA; c.opb = OPB_SZ;
            c.wb_en = 1'b1; c.wb_dst = DST_T; c.wb_add = ADD_NONE;
         end
         4'd2: begin
            c.mul_en = 1'b1; c.opa = OPA_SIGMA; c.opb = OPB_D1;
            c.wb_en = 1'b1; c.wb_dst = DST_FZ; c.wb_add = ADD_T_SUB;
         end
         4'd3: begin
            c.mul_en = 1'b1; c.opa = OPA_SX; c.opb = OPB_D2;
            c.wb_en = 1'b1; c.wb_dst = DST_FX; c.wb_add = ADD_NONE;
         end
         4'd4: begin
            c.mul_en = 1'b1; c.opa = OPA_H; c.opb = OPB_FX;
            c.wb_en = 1'b1; c.wb_dst = DST_FY; c.wb_add = ADD_SUB_Y;
         end
         4'd5: begin
            c.mul_en = 1'b1; c.opa = OPA_H; c.opb = OPB_FY;
            c.wb_en = 1'b1; c.wb_dst = DST_MX; c.wb_add = ADD_PX; c.wb_half = 1'b1;
         end
         4'd6: begin
            c.mul_en = 1'b1; c.opa = OPA_H; c.opb = OPB_FZ;
            c.wb_en = 1'b1; c.wb_dst = DST_MY; c.wb_add = ADD_PY; c.wb_half = 1'b1;
         end
         4'd7: begin
            c.src_m = 1'b1; c.diff_yx = 1'b1;
            c.mul_en = 1'b1; c.opa = OPA_SX; c.opb = OPB_SY;
            c.wb_en = 1'b1; c.wb_dst = DST_MZ; c.wb_add = ADD_PZ; c.wb_half = 1'b1;
         end
         4'd8: begin
            c.src_m = 1'b1; c.diff_rz = 1'b1;
            c.mul_en = 1'b1; c.opa = OPA_BETA; c.opb = OPB_SZ;
            c.wb_en = 1'b1; c.wb_dst = DST_T; c.wb_add = ADD_NONE;
         end
         4'd9: begin
            c.src_m = 1'b1;
            c.mul_en = 1'b1; c.opa = OPA_SIGMA; c.opb = OPB_D1;
            c.wb_en = 1'b1; c.wb_dst = DST_FZ; c.wb_add = ADD_T_SUB;
         end
         4'd10: begin
            c.src_m = 1'b1;
            c.mul_en = 1'b1; c.opa = OPA_SX; c.opb = OPB_D2;
            c.wb_en = 1'b1; c.wb_dst = DST_FX; c.wb_add = ADD_NONE;
         end
         4'd11: begin
            c.src_m = 1'b1;
            c.mul_en = 1'b1; c.opa = OPA_H; c.opb = OPB_FX;
            c.wb_en = 1'b1; c.wb_dst = DST_FY; c.wb_add = ADD_SUB_Y;
         end
         4'd12: begin
            c.mul_en = 1'b1; c.opa = OPA_H; c.opb = OPB_FY;
            c.wb_en = 1'b1; c.wb_dst = DST_PX; c.wb_add = ADD_PX;
         end
         4'd13: begin
            c.mul_en = 1'b1; c.opa = OPA_H; c.opb = OPB_FZ;
            c.wb_en = 1'b1; c.wb_dst = DST_PY; c.wb_add = ADD_PY;
         end
         4'd14: begin
            c.wb_en = 1'b1; c.wb_dst = DST_PZ; c.wb_add = ADD_PZ;
            c.count = 1'b1;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

endpackage

@@ hdl/lmrk_ctrl.sv @@
module lmrk_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output lmrk_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } ctrl_state_type;

   ctrl_state_type              state_ff, state_in;
   logic [lmrk_pkg::UopW-1:0]   uop_ff, uop_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // sequencer next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      uop_in       = uop_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == lmrk_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  cmd.start = 1'b1;
                  uop_in    = '0;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd = lmrk_pkg::rk_uop(uop_ff);
            if (uop_ff == lmrk_pkg::UopLast) begin
               state_in = ST_DONE;
            end else begin
               uop_in = uop_ff + 4'd1;
            end
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         uop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uop_ff       <= uop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/lmrk_dpath.sv @@
module lmrk_dpath #(
   parameter int         FRAC_BITS = 24,
   parameter logic [30:0] STEP_RST  = 31'd167772,
   parameter logic [30:0] SIGMA_RST = 31'd167772160,
   parameter logic [30:0] RHO_RST   = 31'd469762048,
   parameter logic [30:0] BETA_RST  = 31'd44739243
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [lmrk_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lmrk_pkg::CoefW-1:0]   csr_wdata,
   input  logic [95:0]                 req_tdata,
   input  lmrk_pkg::dp_cmd_type        cmd,
   output logic [127:0]                rsp_tdata,
   output logic                        rsp_tuser
);

   localparam logic signed [63:0] SatHi    = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SatLo    = -64'sh0000_0000_8000_0000;
   localparam logic signed [63:0] BiasFull = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] BiasHalf = 64'sd1 <<< FRAC_BITS;

   function automatic logic signed [31:0] sat_val(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SatHi) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SatLo) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic sat_ovf(input logic signed [63:0] v);
      return (v > SatHi) || (v < SatLo);
   endfunction

   // coefficients
   logic [30:0]        step_ff, sigma_ff, rho_ff, beta_ff;
   // state, midpoint, derivatives, differences, partial term
   logic signed [31:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [31:0] mx_ff, my_ff, mz_ff, mx_in, my_in, mz_in;
   logic signed [31:0] fx_ff, fy_ff, fz_ff, fx_in, fy_in, fz_in;
   logic signed [31:0] d1_ff, d2_ff, d1_in, d2_in;
   logic signed [63:0] t_ff, t_in;
   logic [31:0]        steps_ff, steps_in;
   logic               sat_ff, sat_in;
   logic signed [63:0] prod_ff;
   // output register
   logic [31:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_steps_ff;
   logic               rsp_sat_ff;

   logic signed [31:0] src_x, src_y, src_z;
   logic signed [31:0] opa, opb;
   logic signed [63:0] prod_in;
   logic signed [63:0] dyx_wide, drz_wide;
   logic signed [63:0] biased, rnd, wb_sum;
   logic signed [31:0] wb_val;
   logic               wb_ovf;

   // operand source: state or midpoint
   assign src_x = cmd.src_m ? mx_ff : px_ff;
   assign src_y = cmd.src_m ? my_ff : py_ff;
   assign src_z = cmd.src_m ? mz_ff : pz_ff;

   // differences ahead of the derivative products
   assign dyx_wide = 64'(src_y) - 64'(src_x);
   assign drz_wide = $signed({33'd0, rho_ff}) - 64'(src_z);

   // shared multiplier operands
   always_comb begin
      case (cmd.opa)
         lmrk_pkg::OPA_SX:    opa = src_x;
         lmrk_pkg::OPA_BETA:  opa = $signed({1'b0, beta_ff});
         lmrk_pkg::OPA_SIGMA: opa = $signed({1'b0, sigma_ff});
         lmrk_pkg::OPA_H:     opa = $signed({1'b0, step_ff});
         default:             opa = src_x;
      endcase
      case (cmd.opb)
         lmrk_pkg::OPB_SY: opb = src_y;
         lmrk_pkg::OPB_SZ: opb = src_z;
         lmrk_pkg::OPB_D1: opb = d1_ff;
         lmrk_pkg::OPB_D2: opb = d2_ff;
         lmrk_pkg::OPB_FX: opb = fx_ff;
         lmrk_pkg::OPB_FY: opb = fy_ff;
         lmrk_pkg::OPB_FZ: opb = fz_ff;
         default:          opb = src_y;
      endcase
   end

   // signed 32x32 product, sign extended to the full width
   assign prod_in = 64'(opa) * 64'(opb);

   // round to nearest, ties up, then combine with the selected term
   assign biased = prod_ff + (cmd.wb_half ? BiasHalf : BiasFull);
   assign rnd    = cmd.wb_half ? (biased >>> (FRAC_BITS + 1)) : (biased >>> FRAC_BITS);

   always_comb begin
      case (cmd.wb_add)
         lmrk_pkg::ADD_NONE:  wb_sum = rnd;
         lmrk_pkg::ADD_SUB_Y: wb_sum = rnd - 64'(src_y);
         lmrk_pkg::ADD_T_SUB: wb_sum = t_ff - rnd;
         lmrk_pkg::ADD_PX:    wb_sum = rnd + 64'(px_ff);
         lmrk_pkg::ADD_PY:    wb_sum = rnd + 64'(py_ff);
         lmrk_pkg::ADD_PZ:    wb_sum = rnd + 64'(pz_ff);
         default:             wb_sum = rnd;
      endcase
   end

   assign wb_val = sat_val(wb_sum);
   assign wb_ovf = sat_ovf(wb_sum);

   // register updates
   always_comb begin
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      mz_in    = mz_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      fz_in    = fz_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      t_in     = t_ff;
      steps_in = steps_ff;
      sat_in   = sat_ff;

      if (cmd.load) begin
         px_in    = $signed(req_tdata[31:0]);
         py_in    = $signed(req_tdata[63:32]);
         pz_in    = $signed(req_tdata[95:64]);
         steps_in = '0;
         sat_in   = 1'b0;
      end
      if (cmd.start) begin
         sat_in = 1'b0;
      end
      if (cmd.diff_yx) begin
         d1_in = sat_val(dyx_wide);
         if (sat_ovf(dyx_wide)) begin
            sat_in = 1'b1;
         end
      end
      if (cmd.diff_rz) begin
         d2_in = sat_val(drz_wide);
         if (sat_ovf(drz_wide)) begin
            sat_in = 1'b1;
         end
      end
      if (cmd.wb_en) begin
         if (cmd.wb_dst != lmrk_pkg::DST_T && wb_ovf) begin
            sat_in = 1'b1;
         end
         case (cmd.wb_dst)
            lmrk_pkg::DST_T:  t_in  = wb_sum;
            lmrk_pkg::DST_FX: fx_in = wb_val;
            lmrk_pkg::DST_FY: fy_in = wb_val;
            lmrk_pkg::DST_FZ: fz_in = wb_val;
            lmrk_pkg::DST_MX: mx_in = wb_val;
            lmrk_pkg::DST_MY: my_in = wb_val;
            lmrk_pkg::DST_MZ: mz_in = wb_val;
            lmrk_pkg::DST_PX: px_in = wb_val;
            lmrk_pkg::DST_PY: py_in = wb_val;
            lmrk_pkg::DST_PZ: pz_in = wb_val;
            default:          t_in  = t_ff;
         endcase
      end
      if (cmd.count) begin
         steps_in = steps_ff + 32'd1;
      end
   end

   // coefficients, state and flag
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_RST;
         sigma_ff <= SIGMA_RST;
         rho_ff   <= RHO_RST;
         beta_ff  <= BETA_RST;
         px_ff    <= '0;
         py_ff    <= '0;
         pz_ff    <= '0;
         steps_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               lmrk_pkg::CSR_STEP:  step_ff  <= csr_wdata;
               lmrk_pkg::CSR_SIGMA: sigma_ff <= csr_wdata;
               lmrk_pkg::CSR_RHO:   rho_ff   <= csr_wdata;
               lmrk_pkg::CSR_BETA:  beta_ff  <= csr_wdata;
               default:             step_ff  <= step_ff;
            endcase
         end
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         steps_ff <= steps_in;
         sat_ff   <= sat_in;
      end
   end

   // scratch registers and product
   always_ff @(posedge clock) begin
      mx_ff <= mx_in;
      my_ff <= my_in;
      mz_ff <= mz_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fz_ff <= fz_in;
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      t_ff  <= t_in;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_x_ff     <= px_ff;
         rsp_y_ff     <= py_ff;
         rsp_z_ff     <= pz_ff;
         rsp_steps_ff <= steps_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_tdata = {rsp_steps_ff, rsp_z_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser = rsp_sat_ff;

endmodule

@@ hdl/lorenz_midpoint_rk2_step_top.sv @@
// Lorenz system integrator, second-order midpoint Runge-Kutta, signed fixed
// point with FRAC_BITS fraction bits (Q8.24 by default). A beat with tuser 0
// loads x, y, z and clears the step count; a beat with tuser 1 takes one step
// of size h and returns the new state, the step count and a flag that is set
// when any intermediate value saturated to 32 bits. A load also returns a
// result. In a step the sequencer passes the 14 products one after another
// through the single 32x32 multiplier and its rounding stage, and then moves
// the result into the output register. The next request is accepted in the
// cycle after that move, while the result may still wait for rsp_tready.
// The user must write coefficients through the csr port while idle; the
// block itself does not enforce it.
module lorenz_midpoint_rk2_step_top #(
   parameter int FRAC_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   // configuration write port
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // load_x, load_y, load_z
   input  logic         req_tuser,   // cmd
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_x, out_y, out_z, step_count
   output logic         rsp_tuser    // saturated
);

   // reset coefficients, rounded to nearest and clipped to 31 bits
   localparam longint unsigned One      = 64'd1 << FRAC_BITS;
   localparam longint unsigned StepRaw  = (2 * 1 * One / 100 + 1) / 2;
   localparam longint unsigned SigmaRaw = (2 * 10 * One / 1 + 1) / 2;
   localparam longint unsigned RhoRaw   = (2 * 28 * One / 1 + 1) / 2;
   localparam longint unsigned BetaRaw  = (2 * 8 * One / 3 + 1) / 2;
   localparam longint unsigned CoefMax  = 64'h7FFF_FFFF;
   localparam logic [30:0] StepRst  = (StepRaw > CoefMax) ? '1 : StepRaw[30:0];
   localparam logic [30:0] SigmaRst = (SigmaRaw > CoefMax) ? '1 : SigmaRaw[30:0];
   localparam logic [30:0] RhoRst   = (RhoRaw > CoefMax) ? '1 : RhoRaw[30:0];
   localparam logic [30:0] BetaRst  = (BetaRaw > CoefMax) ? '1 : BetaRaw[30:0];

   lmrk_pkg::dp_cmd_type cmd;

   lmrk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lmrk_dpath #(
      .FRAC_BITS (FRAC_BITS),
      .STEP_RST  (StepRst),
      .SIGMA_RST (SigmaRst),
      .RHO_RST   (RhoRst),
      .BETA_RST  (BetaRst)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ tb/lorenz_step_checker.sv @@
`timescale 1ns / 1ps

module lorenz_step_checker #(
   parameter int FRAC_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [95:0]  req_tdata,   // load_x, load_y, load_z
   input  logic         req_tuser,   // cmd
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,   // out_x, out_y, out_z, step_count
   input  logic         rsp_tuser,   // saturated
   output int           mismatch_count,
   output int           results_pending
);

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] steps;
      logic        sat;
   } lorenz_result_type;

   // coefficient values after reset, Q8.24
   localparam longint StepReset  = 167772;
   localparam longint SigmaReset = 167772160;
   localparam longint RhoReset   = 469762048;
   localparam longint BetaReset  = 44739243;

   localparam longint SatMax = 64'sh7FFFFFFF;
   localparam longint SatMin = -64'sh80000000;

   longint            step_h;
   longint            sigma_k;
   longint            rho_k;
   longint            beta_k;
   longint            pos_x;
   longint            pos_y;
   longint            pos_z;
   logic [31:0]       step_total;
   bit                sat_seen;
   lorenz_result_type expected_states[$];

   // clamp to signed 32 bits and note any clipping
   function automatic longint clamp32(input longint v);
      if (v > SatMax) begin
         sat_seen = 1'b1;
         return SatMax;
      end
      if (v < SatMin) begin
         sat_seen = 1'b1;
         return SatMin;
      end
      return v;
   endfunction

   // exact product, rounded half up, shifted down
   function automatic longint scaled_product(input longint a, input longint b,
                                             input int shift);
      longint p;
      p = a * b + (64'sd1 <<< (shift - 1));
      return p >>> shift;
   endfunction

   // lorenz derivatives at one point
   task automatic lorenz_rates(input longint x, input longint y, input longint z,
                               output longint fx, output longint fy,
                               output longint fz);
      longint dyx;
      longint drz;
      dyx = clamp32(y - x);
      drz = clamp32(rho_k - z);
      fx  = clamp32(scaled_product(sigma_k, dyx, FRAC_BITS));
      fy  = clamp32(scaled_product(x, drz, FRAC_BITS) - y);
      fz  = clamp32(scaled_product(x, y, FRAC_BITS) -
                    scaled_product(beta_k, z, FRAC_BITS));
   endtask

   // apply one request to the state and queue the resulting beat
   task automatic predict_request(input logic cmd_bit, input logic [95:0] data);
      longint            fx, fy, fz;
      longint            gx, gy, gz;
      longint            mx, my, mz;
      lorenz_result_type r;
      sat_seen = 1'b0;
      if (lmrk_pkg::req_cmd_type'(cmd_bit) == lmrk_pkg::CMD_LOAD) begin
         pos_x      = longint'($signed(data[31:0]));
         pos_y      = longint'($signed(data[63:32]));
         pos_z      = longint'($signed(data[95:64]));
         step_total = '0;
      end else begin
         lorenz_rates(pos_x, pos_y, pos_z, fx, fy, fz);
         // half step to the midpoint
         mx = clamp32(pos_x + scaled_product(step_h, fx, FRAC_BITS + 1));
         my = clamp32(pos_y + scaled_product(step_h, fy, FRAC_BITS + 1));
         mz = clamp32(pos_z + scaled_product(step_h, fz, FRAC_BITS + 1));
         // full step along the midpoint slope
         lorenz_rates(mx, my, mz, gx, gy, gz);
         pos_x      = clamp32(pos_x + scaled_product(step_h, gx, FRAC_BITS));
         pos_y      = clamp32(pos_y + scaled_product(step_h, gy, FRAC_BITS));
         pos_z      = clamp32(pos_z + scaled_product(step_h, gz, FRAC_BITS));
         step_total = step_total + 32'd1;
      end
      r.x     = pos_x[31:0];
      r.y     = pos_y[31:0];
      r.z     = pos_z[31:0];
      r.steps = step_total;
      r.sat   = sat_seen;
      expected_states.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // compare one result beat against the oldest prediction
   task automatic check_response();
      lorenz_result_type r;
      if (expected_states.size() == 0) begin
         report_mismatch("unexpected result beat, out_x", rsp_tdata[31:0], '0);
      end else begin
         r = expected_states.pop_front();
         if (rsp_tdata[31:0] !== r.x) report_mismatch("out_x", rsp_tdata[31:0], r.x);
         if (rsp_tdata[63:32] !== r.y) report_mismatch("out_y", rsp_tdata[63:32], r.y);
         if (rsp_tdata[95:64] !== r.z) report_mismatch("out_z", rsp_tdata[95:64], r.z);
         if (rsp_tdata[127:96] !== r.steps) begin
            report_mismatch("step_count", rsp_tdata[127:96], r.steps);
         end
         if (rsp_tuser !== r.sat) begin
            report_mismatch("saturated", {31'b0, rsp_tuser}, {31'b0, r.sat});
         end
      end
   endtask

   // track coefficient writes, requests and results
   always @(posedge clock) begin
      if (reset) begin
         step_h     = StepReset;
         sigma_k    = SigmaReset;
         rho_k      = RhoReset;
         beta_k     = BetaReset;
         pos_x      = 0;
         pos_y      = 0;
         pos_z      = 0;
         step_total = '0;
         expected_states.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (lmrk_pkg::csr_idx_type'(csr_index))
               lmrk_pkg::CSR_STEP:  step_h  = longint'(csr_wdata);
               lmrk_pkg::CSR_SIGMA: sigma_k = longint'(csr_wdata);
               lmrk_pkg::CSR_RHO:   rho_k   = longint'(csr_wdata);
               lmrk_pkg::CSR_BETA:  beta_k  = longint'(csr_wdata);
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
      end
      results_pending = expected_states.size();
   end

endmodule

@@ tb/tb_lorenz_midpoint_rk2_step_top.sv @@
`timescale 1ns / 1ps

module tb_lorenz_midpoint_rk2_step_top;

   localparam int FracBits   = 24;
   localparam int CycleLimit = 1_000_000;
   localparam int PhaseCount = 10;
   localparam int PhaseItems = 190;
   localparam int LongHold   = 400;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         csr_we      = 1'b0;
   logic [1:0]   csr_index   = '0;
   logic [30:0]  csr_wdata   = '0;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata   = '0;
   logic         req_tuser   = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;

   int mismatch_count;
   int results_pending;
   int cycle_count   = 0;
   int req_max_gap   = 14;
   int rsp_max_stall = 14;
   bit long_hold_req = 1'b0;

   always #5 clock = ~clock;

   lorenz_midpoint_rk2_step_top #(
      .FRAC_BITS (FracBits)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lorenz_step_checker #(
      .FRAC_BITS (FracBits)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("lorenz_midpoint_rk2_step_top test failed");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LongHold;
         end else begin
            stall = $urandom_range(0, rsp_max_stall);
         end
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // present one request beat and wait for it to be taken
   task automatic offer_request(input lmrk_pkg::req_cmd_type cmd, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // step with junk on the ignored coordinates
   task automatic offer_step();
      offer_request(lmrk_pkg::CMD_STEP, $urandom, $urandom, $urandom);
   endtask

   // mostly stepping trajectories from plausible starts, some raw loads
   task automatic send_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
         offer_request(lmrk_pkg::CMD_LOAD,
                       $urandom_range(0, 32'd1342177280) - 32'd671088640,
                       $urandom_range(0, 32'd1342177280) - 32'd671088640,
                       $urandom_range(0, 32'd1342177280) - 32'd671088640);
      end else if (pick < 10) begin
         offer_request(lmrk_pkg::CMD_LOAD, $urandom, $urandom, $urandom);
      end else begin
         offer_step();
      end
   endtask

   // stop offering and wait until every result beat is back
   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write all four coefficients back to back
   task automatic write_coefs(input logic [30:0] h, input logic [30:0] sigma,
                              input logic [30:0] rho, input logic [30:0] beta);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= lmrk_pkg::CSR_STEP;
      csr_wdata <= h;
      @(negedge clock);
      csr_index <= lmrk_pkg::CSR_SIGMA;
      csr_wdata <= sigma;
      @(negedge clock);
      csr_index <= lmrk_pkg::CSR_RHO;
      csr_wdata <= rho;
      @(negedge clock);
      csr_index <= lmrk_pkg::CSR_BETA;
      csr_wdata <= beta;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // stimulus and verdict
   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed beats under the reset coefficients
      offer_step();
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
      offer_step();
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      offer_step();
      offer_request(lmrk_pkg::CMD_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      offer_step();

      // random phases, each under its own coefficient set
      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_drained();
         if (phase == 0) begin
            write_coefs(31'd167772, 31'd167772160, 31'd469762048, 31'd44739243);
         end else if (phase == 1) begin
            write_coefs('1, '1, '1, '1);
         end else if (phase == 2) begin
            write_coefs('0, '0, '0, '0);
         end else if (phase == 4 || phase == 7) begin
            write_coefs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
         end else begin
            write_coefs(31'($urandom_range(32'h1_0000, 32'h20_0000)),
                        31'($urandom_range(32'h500_0000, 32'hF00_0000)),
                        31'($urandom_range(32'h100_0000, 32'h2800_0000)),
                        31'($urandom_range(32'h80_0000, 32'h400_0000)));
         end
         req_max_gap   = (phase % 3 == 1) ? 0 : 14;
         rsp_max_stall = (phase % 3 == 1) ? 0 : 14;
         for (int n = 0; n < PhaseItems; n++) begin
            if (phase == 5 && n == 30) long_hold_req = 1'b1;
            send_random_request();
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lorenz_midpoint_rk2_step_top test passed");
      end else begin
         $display("lorenz_midpoint_rk2_step_top test failed");
      end
      $finish;
   end

endmodule
